// File: design/c3gf_pkg.sv
// ----------------------------------------------------------------------------
// c3gf_pkg: shared types and constants of the 3x3 grayscale filter
// Geometry limits, configuration register codes, queue entry and status types.
// ----------------------------------------------------------------------------
package c3gf_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int WID_BITS  = 13;
  localparam int HGT_BITS  = 16;
  localparam int COEF_BITS = 8;
  localparam int ROW_BITS  = 3 * COEF_BITS;
  localparam int PROD_BITS = 9 + COEF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 4;
  localparam int Q_DEPTH   = 4;
  localparam int QP_BITS   = $clog2(Q_DEPTH);

  localparam logic [WID_BITS-1:0] MIN_DIM      = WID_BITS'(3);
  localparam logic [WID_BITS-1:0] MAX_WID_VAL  = WID_BITS'(MAX_WIDTH);
  localparam logic [HGT_BITS-1:0] MIN_HGT      = HGT_BITS'(3);

  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_COEF_TOP     = 3'd2;
  localparam logic [2:0] REG_COEF_MID     = 3'd3;
  localparam logic [2:0] REG_COEF_BOT     = 3'd4;
  localparam logic [2:0] REG_DIVISOR      = 3'd5;

  typedef struct packed {
    logic [WID_BITS-1:0]          frame_width;
    logic [HGT_BITS-1:0]          frame_height;
    logic [2:0][ROW_BITS-1:0]     coef;
    logic [7:0]                   divisor;
  } cfg_t;

  // Window pixels, index = column * 3 + row, column 0 is the leftmost.
  typedef struct packed {
    logic [8:0][7:0] pix;
    logic            last;
  } win_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic signed [COEF_BITS-1:0] coef_at(cfg_t c, int r, int k);
    coef_at = c.coef[r][k*COEF_BITS +: COEF_BITS];
  endfunction

endpackage

// File: design/c3gf_pix_if.sv
// ----------------------------------------------------------------------------
// c3gf_pix_if: input pixel channel
// Valid/ready channel carrying one raster pixel and its frame start mark.
// ----------------------------------------------------------------------------
interface c3gf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// File: design/c3gf_res_if.sv
// ----------------------------------------------------------------------------
// c3gf_res_if: filtered result channel
// Valid/ready channel carrying one filtered value and its end of frame mark.
// ----------------------------------------------------------------------------
interface c3gf_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] filtered;
  logic       frame_last;
  modport source (output valid, output filtered, output frame_last, input ready);
  modport sink   (input valid, input filtered, input frame_last, output ready);
endinterface

// File: design/c3gf_front.sv
// ----------------------------------------------------------------------------
// c3gf_front: pixel intake, line stores and window
// Tracks position, reads the two line stores, builds interior windows.
// ----------------------------------------------------------------------------
module c3gf_front (
  input  logic            clk,
  input  logic            rst,
  c3gf_pix_if.sink        pix,
  input  c3gf_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            push,
  output c3gf_pkg::win_t  push_data
);
  import c3gf_pkg::*;

  typedef enum logic [1:0] {F_IDLE = 2'b01, F_WORK = 2'b10} fstate_t;

  fstate_t               state;
  logic [7:0]            store_a [MAX_WIDTH];
  logic [7:0]            store_b [MAX_WIDTH];
  logic [7:0]            rd_a, rd_b, px_hold;
  logic [5:0][7:0]       win;
  logic [COL_BITS-1:0]   col, cur_col, acc_col;
  logic [HGT_BITS-1:0]   row, cur_row, acc_row;
  logic [WID_BITS-1:0]   w, wm1, colx;
  logic [HGT_BITS-1:0]   h, hm1;
  logic                  accept, row_end, frame_end, produce;

  assign pix.ready = (state == F_IDLE) && !q_full;
  assign accept    = pix.valid && pix.ready;
  assign acc_col   = pix.frame_start ? '0 : col;
  assign acc_row   = pix.frame_start ? '0 : row;

  always_comb begin
    if (cfg.frame_width < MIN_DIM) w = MIN_DIM;
    else if (cfg.frame_width > MAX_WID_VAL) w = MAX_WID_VAL;
    else w = cfg.frame_width;
    h = (cfg.frame_height < MIN_HGT) ? MIN_HGT : cfg.frame_height;
  end

  assign wm1       = w - WID_BITS'(1);
  assign hm1       = h - HGT_BITS'(1);
  assign colx      = WID_BITS'(cur_col);
  assign row_end   = colx >= wm1;
  assign frame_end = row_end && (cur_row >= hm1);
  assign produce   = (colx >= WID_BITS'(2)) && (cur_row >= HGT_BITS'(2)) &&
                     (colx < w) && (cur_row < h);

  assign push           = (state == F_WORK) && produce;
  assign push_data.pix  = {px_hold, rd_a, rd_b, win};
  assign push_data.last = (colx == wm1) && (cur_row == hm1);

  // line stores: read on accept, write back in the work cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a <= store_a[acc_col];
      rd_b <= store_b[acc_col];
    end
    if (state == F_WORK) begin
      store_a[cur_col] <= px_hold;
      store_b[cur_col] <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_hold <= pix.pixel;
      cur_col <= acc_col;
      cur_row <= acc_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
      win   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) state <= F_WORK;
        end
        F_WORK: begin
          win <= {px_hold, rd_a, rd_b, win[5:3]};
          if (frame_end) begin
            col <= '0;
            row <= '0;
          end else if (row_end) begin
            col <= '0;
            row <= cur_row + HGT_BITS'(1);
          end else begin
            col <= cur_col + COL_BITS'(1);
            row <= cur_row;
          end
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

// File: design/c3gf_queue.sv
// ----------------------------------------------------------------------------
// c3gf_queue: window queue
// Small register FIFO between intake and arithmetic.
// ----------------------------------------------------------------------------
module c3gf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  c3gf_pkg::win_t    push_data,
  input  logic              pop,
  output c3gf_pkg::win_t    pop_data,
  output c3gf_pkg::q_stat_t stat
);
  import c3gf_pkg::*;

  win_t               mem [Q_DEPTH];
  logic [QP_BITS-1:0] wr_ptr, rd_ptr;
  logic [QP_BITS:0]   count;

  assign stat.full  = count == (QP_BITS+1)'(Q_DEPTH);
  assign stat.empty = count == '0;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QP_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QP_BITS'(1);
      case ({push, pop})
        2'b10:   count <= count + (QP_BITS+1)'(1);
        2'b01:   count <= count - (QP_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

// File: design/c3gf_back.sv
// ----------------------------------------------------------------------------
// c3gf_back: weighted sum, division and clamp
// Multiplies, sums, divides by the divisor bit by bit or clamps, and drives results.
// ----------------------------------------------------------------------------
module c3gf_back (
  input  logic              clk,
  input  logic              rst,
  input  c3gf_pkg::cfg_t    cfg,
  input  c3gf_pkg::q_stat_t q_stat,
  input  c3gf_pkg::win_t    q_data,
  output logic              pop,
  c3gf_res_if.source        res
);
  import c3gf_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001, B_MUL = 6'b000010, B_SUM = 6'b000100,
    B_CHK  = 6'b001000, B_DIV = 6'b010000, B_OUT = 6'b100000
  } bstate_t;

  bstate_t                     state;
  win_t                        item;
  logic signed [PROD_BITS-1:0] prod [9];
  logic signed [SUM_BITS-1:0]  sum, sum_next;
  logic [7:0]                  d, rem, num, res_val;
  logic [8:0]                  rem9;
  logic                        ge;
  logic [2:0]                  cnt;
  logic                        out_valid;
  logic [7:0]                  out_val;
  logic                        out_last;
  logic                        load;

  assign pop       = (state == B_IDLE) && !q_stat.empty;
  assign d         = (cfg.divisor == 8'd0) ? 8'd1 : cfg.divisor;
  assign rem9      = {rem, num[7]};
  assign ge        = rem9 >= {1'b0, d};
  assign load      = (state == B_OUT) && (!out_valid || res.ready);
  assign res.valid      = out_valid;
  assign res.filtered   = out_val;
  assign res.frame_last = out_last;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < 9; i++) sum_next = sum_next + SUM_BITS'(prod[i]);
  end

  always_ff @(posedge clk) begin
    if (pop) item <= q_data;
    if (state == B_MUL) begin
      for (int i = 0; i < 9; i++)
        prod[i] <= $signed({1'b0, item.pix[i]}) * coef_at(cfg, i % 3, i / 3);
    end
    if (state == B_SUM) sum <= sum_next;
    if (state == B_CHK) begin
      rem     <= sum[15:8];
      num     <= sum[7:0];
      res_val <= (sum <= 0) ? 8'd0 : 8'd255;
    end
    if (state == B_DIV) begin
      rem <= ge ? 8'(rem9 - {1'b0, d}) : rem9[7:0];
      num <= {num[6:0], ge};
      if (cnt == 3'd0) res_val <= {num[6:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: if (pop) state <= B_MUL;
        B_MUL:  state <= B_SUM;
        B_SUM:  state <= B_CHK;
        B_CHK: begin
          cnt <= 3'd7;
          if (sum <= 0 || sum >= $signed(SUM_BITS'({d, 8'd0}))) state <= B_OUT;
          else state <= B_DIV;
        end
        B_DIV: begin
          cnt <= cnt - 3'd1;
          if (cnt == 3'd0) state <= B_OUT;
        end
        B_OUT: begin
          if (load) begin
            out_val  <= res_val;
            out_last <= item.last;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule

// File: design/conv3x3_gray_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_gray_filter: streaming 3x3 grayscale convolution
// Raster pixels in, clamped filtered values of interior pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one pixel per transaction in raster order; frame_start
//   puts that pixel at column 0, row 0. A frame also wraps on its own after
//   its last pixel. res_out carries one transaction per interior pixel;
//   frame_last marks the one formed by the last pixel of the frame. Border
//   pixels give nothing; downstream fills them.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Flow:
//   The intake takes no new pixel until the last one is written back: the
//   line store read issued at acceptance returns the next cycle, when the
//   store is written back. The arithmetic pops a window only when idle,
//   then multiplies, sums, checks the range and loads the output register,
//   with bit-serial division after the range check when the sum is positive
//   and below 256 times the divisor. A four-entry queue separates intake
//   from arithmetic, so pixels keep flowing while a result waits.
// Reset and stalls:
//   Reset clears position, window, queue and output valid; line stores hold
//   anything until written. A stalled receiver holds the output register,
//   the arithmetic waits, the queue fills and then pix_in.ready drops.
// ----------------------------------------------------------------------------
module conv3x3_gray_filter (
  input  logic        clk,
  input  logic        rst,
  c3gf_pix_if.sink    pix_in,
  c3gf_res_if.source  res_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import c3gf_pkg::*;

  cfg_t    cfg;
  win_t    push_data, pop_data;
  q_stat_t q_stat;
  logic    push, pop;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= WID_BITS'(640);
      cfg.frame_height <= HGT_BITS'(480);
      cfg.coef[0]      <= ROW_BITS'(24'h010201);
      cfg.coef[1]      <= ROW_BITS'(24'h020402);
      cfg.coef[2]      <= ROW_BITS'(24'h010201);
      cfg.divisor      <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[WID_BITS-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[HGT_BITS-1:0];
        REG_COEF_TOP:     cfg.coef[0]      <= cfg_data[ROW_BITS-1:0];
        REG_COEF_MID:     cfg.coef[1]      <= cfg_data[ROW_BITS-1:0];
        REG_COEF_BOT:     cfg.coef[2]      <= cfg_data[ROW_BITS-1:0];
        REG_DIVISOR:      cfg.divisor      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // intake: position tracking, line stores, window
  c3gf_front u_front (
    .clk(clk), .rst(rst), .pix(pix_in), .cfg(cfg),
    .q_full(q_stat.full), .push(push), .push_data(push_data)
  );

  // hand windows over to the arithmetic
  c3gf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .stat(q_stat)
  );

  // weighted sum, divide, clamp, output register
  c3gf_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_stat(q_stat),
    .q_data(pop_data), .pop(pop), .res(res_out)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full) else $error("window queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty) else $error("window queue underflow");

  a_intake_gap: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready) |=> !pix_in.ready)
    else $error("intake took pixels on consecutive cycles");

endmodule

// File: sim/tb_c3gf_if_note.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3gf_score: scoreboard of the 3x3 grayscale filter bench
// Predicts filtered values from the pixel stream and checks every result.
// ----------------------------------------------------------------------------
class c3gf_score;
  logic [12:0] width_q;
  logic [15:0] height_q;
  logic [23:0] coef_q [3];
  logic [7:0]  div_q;
  logic [7:0]  row_a [4096];
  logic [7:0]  row_b [4096];
  logic [7:0]  win [6];
  int unsigned col_pos, row_pos;
  logic [8:0]  pending [$];
  int          mismatches;
  int          results_seen;
  int          frames_seen;

  function new();
    width_q = 640; height_q = 480;
    coef_q[0] = 24'h010201; coef_q[1] = 24'h020402; coef_q[2] = 24'h010201;
    div_q = 16;
    foreach (win[i]) win[i] = 0;
    col_pos = 0; row_pos = 0;
    mismatches = 0; results_seen = 0; frames_seen = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      c3gf_pkg::REG_FRAME_WIDTH:  width_q = val[12:0];
      c3gf_pkg::REG_FRAME_HEIGHT: height_q = val[15:0];
      c3gf_pkg::REG_COEF_TOP:     coef_q[0] = val;
      c3gf_pkg::REG_COEF_MID:     coef_q[1] = val;
      c3gf_pkg::REG_COEF_BOT:     coef_q[2] = val;
      c3gf_pkg::REG_DIVISOR:      div_q = val[7:0];
      default: ;
    endcase
  endfunction

  function void note_pixel(logic [7:0] px, logic fs);
    int unsigned w, h;
    longint sum, d;
    logic [7:0] up1, up2, cell_v [9];
    logic signed [7:0] k;
    bit row_end, frame_end;
    w = width_q; h = height_q;
    if (w < 3) w = 3;
    if (w > 4096) w = 4096;
    if (h < 3) h = 3;
    d = (div_q == 0) ? 1 : div_q;
    if (fs) begin
      col_pos = 0; row_pos = 0;
    end
    up1 = 0; up2 = 0;
    if (col_pos < 4096) begin
      up1 = row_a[col_pos]; up2 = row_b[col_pos];
    end
    row_end = col_pos >= w - 1;
    frame_end = row_end && row_pos >= h - 1;
    if (col_pos >= 2 && row_pos >= 2 && col_pos < w && row_pos < h) begin
      for (int i = 0; i < 6; i++) cell_v[i] = win[i];
      cell_v[6] = up2; cell_v[7] = up1; cell_v[8] = px;
      sum = 0;
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < 3; r++) begin
          k = coef_q[r][c*8 +: 8];
          sum += longint'(cell_v[c*3+r]) * longint'(k);
        end
      sum = sum / d;
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      pending.push_back({(col_pos == w - 1 && row_pos == h - 1), sum[7:0]});
    end
    win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
    win[3] = up2; win[4] = up1; win[5] = px;
    if (col_pos < 4096) begin
      row_b[col_pos] = up1; row_a[col_pos] = px;
    end
    if (frame_end) begin
      col_pos = 0; row_pos = 0;
    end else if (row_end) begin
      col_pos = 0; row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  function void check_result(logic [7:0] filt, logic last);
    logic [8:0] exp_v;
    results_seen++;
    if (last) frames_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result filtered=%0d frame_last=%0b", filt, last);
      return;
    end
    exp_v = pending.pop_front();
    if (exp_v[7:0] !== filt || exp_v[8] !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected filtered=%0d last=%0b, got filtered=%0d last=%0b",
                 exp_v[7:0], exp_v[8], filt, last);
    end
  endfunction
endclass

// File: sim/tb_conv3x3_gray_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_gray_filter: self-checking bench of the 3x3 grayscale filter
// Streams frames under several geometries and kernels, with random gaps and
// receiver stalls, and checks each filtered value against a local predictor.
// ----------------------------------------------------------------------------
module tb_conv3x3_gray_filter;
  import c3gf_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  c3gf_pix_if pix_if ();
  c3gf_res_if res_if ();

  conv3x3_gray_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_if.sink),
    .res_out   (res_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  c3gf_score filt_board;
  bit        stall_hold;    // receiver long hold-off request
  bit        stim_done;
  int        idle_cycles;
  int        pixels_sent;
  int unsigned cur_w, cur_h;

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  initial begin
    filt_board = new();
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_FRAME_WIDTH; cfg_data = '0;
    pix_if.valid = 1'b0; pix_if.pixel = '0; pix_if.frame_start = 1'b0;
    res_if.ready = 1'b0;
    stall_hold = 1'b0; stim_done = 1'b0; pixels_sent = 0;
    cur_w = 640; cur_h = 480;
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", filt_board.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random ready gaps, plus a long hold while stall_hold is set.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall_hold) begin
        res_if.ready <= 1'b0;
        repeat (300) @(negedge clk);
        stall_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
      filt_board.check_result(res_if.filtered, res_if.frame_last);
      @(negedge clk);
    end
  end

  // Write one register; only called while the block is idle.
  task automatic write_cfg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    filt_board.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drop the pixel offer, drain all expected results, then let the pipeline settle.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (filt_board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // Offer one pixel and hold it until the transaction completes; the offer
  // stays up for a back-to-back successor and drops on a gap or a drain.
  task automatic send_pixel(logic [7:0] px, logic fs, bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_if.valid <= 1'b1; pix_if.pixel <= px; pix_if.frame_start <= fs;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    filt_board.note_pixel(px, fs);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Set geometry, kernel and divisor between frames.
  task automatic setup(int unsigned w, int unsigned h, logic [23:0] t, logic [23:0] m,
                       logic [23:0] b, logic [7:0] dv);
    wait_drained();
    write_cfg(REG_FRAME_WIDTH, 24'(w));
    write_cfg(REG_FRAME_HEIGHT, 24'(h));
    write_cfg(REG_COEF_TOP, t);
    write_cfg(REG_COEF_MID, m);
    write_cfg(REG_COEF_BOT, b);
    write_cfg(REG_DIVISOR, dv);
    cur_w = (w < 3) ? 3 : ((w > 4096) ? 4096 : w);
    cur_h = (h < 3) ? 3 : h;
  endtask

  // Stream one full frame; mode 0 random, 1 all max, 2 all zero, 3 alternating.
  task automatic send_frame(int mode, bit mark_start, bit no_gap);
    logic [7:0] px;
    for (int i = 0; i < cur_w * cur_h; i++) begin
      case (mode)
        1: px = 8'hFF;
        2: px = 8'h00;
        3: px = (i % 2) ? 8'hFF : 8'h00;
        default: px = 8'($urandom_range(0, 255));
      endcase
      send_pixel(px, mark_start && (i == 0), no_gap);
    end
  endtask

  initial begin
    int unsigned w, h, cut;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: default blur, extremes of pixel values, smallest frame.
    setup(3, 3, 24'h010201, 24'h020402, 24'h010201, 8'd16);
    send_frame(1, 1'b1, 1'b0);
    send_frame(2, 1'b0, 1'b0);           // implicit wrap, no frame_start
    // Negative kernel, clamp at both ends, divisor 1 and zero divisor.
    setup(4, 3, 24'hFFFFFF, 24'hFF08FF, 24'hFFFFFF, 8'd1);
    send_frame(3, 1'b1, 1'b0);
    setup(3, 3, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0);
    send_frame(1, 1'b1, 1'b0);
    // Most negative coefficients, largest divisor, width/height below minimum.
    setup(1, 0, 24'h808080, 24'h808080, 24'h818181, 8'd255);
    send_frame(3, 1'b1, 1'b0);

    // Geometry shrunk mid-frame, then restart via frame_start.
    setup(6, 4, 24'h010201, 24'h020402, 24'h010201, 8'd16);
    for (int i = 0; i < 15; i++) send_pixel(8'($urandom_range(0, 255)), i == 0, 1'b0);
    wait_drained();
    write_cfg(REG_FRAME_WIDTH, 24'd4);
    write_cfg(REG_FRAME_HEIGHT, 24'd3);
    cur_w = 4; cur_h = 3;
    for (int i = 0; i < 6; i++) send_pixel(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_frame(0, 1'b1, 1'b0);

    // Pressure: receiver holds off while the sender keeps offering pixels.
    setup(8, 6, 24'($urandom), 24'($urandom), 24'($urandom), 8'($urandom_range(1, 255)));
    stall_hold = 1'b1;
    send_frame(0, 1'b1, 1'b1);
    wait_drained();

    // Random phases: mostly well-formed frames, some broken ones.
    while (pixels_sent < 700) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(3, 12);
      h = (w > 12) ? 3 : $urandom_range(3, 8);
      setup(w, h, 24'($urandom), 24'($urandom), 24'($urandom),
            8'($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(1, 255)));
      send_frame(0, 1'b1, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        // Broken frame: cut short and restarted with frame_start.
        cut = $urandom_range(1, w * 2);
        for (int i = 0; i < cut; i++)
          send_pixel(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_frame(0, 1'b1, 1'b0);
      end else if (w <= 12) begin
        send_frame(0, 1'b0, 1'b0);
      end
    end

    // Restore the reset kernel as a final setting.
    setup(40, 3, 24'h010201, 24'h020402, 24'h010201, 8'd16);
    send_frame(0, 1'b1, 1'b1);

    wait_drained();
    stim_done = 1'b1;
    $display("Sent %0d pixels, checked %0d results over %0d frames.",
             pixels_sent, filt_board.results_seen, filt_board.frames_seen);
    if (filt_board.mismatches == 0 && filt_board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing",
               filt_board.mismatches, filt_board.pending.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
